>>> hw/rtl/qmm_pkg.sv
// Shared types, register indexes and reset values for the quad motor mixer.
// No dependencies; used by the top level and by its port checker.
package qmm_pkg;

   localparam int MOTORS           = 4;
   localparam int COMMAND_BITS_DEF = 16;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 40;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRUST_GAIN     = 3'd0,
      CSR_ROLL_PITCH_GAIN = 3'd1,
      CSR_YAW_GAIN        = 3'd2,
      CSR_QUAD_GAIN       = 3'd3,
      CSR_LIN_GAIN        = 3'd4,
      CSR_IDLE_LEVEL      = 3'd5
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [31:0] THRUST_GAIN_RST     = 32'd819200;
   localparam logic [31:0] ROLL_PITCH_GAIN_RST = 32'd23406;
   localparam logic [31:0] YAW_GAIN_RST        = 32'd81920;
   localparam logic [39:0] QUAD_GAIN_RST       = 40'd17451182;
   localparam logic [39:0] LIN_GAIN_RST        = 40'd67552963619;
   localparam logic [15:0] IDLE_LEVEL_RST      = 16'd6553;

   // Result mode codes.
   typedef enum logic [1:0] {
      MODE_STOP = 2'd0,
      MODE_IDLE = 2'd1,
      MODE_MIX  = 2'd2
   } drive_mode_type;

   // Per-motor subtract flags: bit 2 roll, bit 1 pitch, bit 0 yaw.
   localparam logic [2:0] MIX_NEG [MOTORS] = '{3'b111, 3'b100, 3'b001, 3'b010};

   // Item control that travels beside the data through the pipeline.
   typedef struct packed {
      logic armed;
      logic hpos;
   } item_ctl_type;

endpackage

>>> hw/rtl/quad_motor_mixer_unit.sv
// Top level of the quad motor mixer: a nine-stage pipeline from demands to commands.
// Depends on qmm_pkg.
//
//   channel | ports | transfer when
//   input   | req_* | req_valid && req_ready
//   result  | rsp_* | rsp_valid && rsp_ready
//   config  | csr_* | csr_we high
//
// One item may enter every cycle while the result is not stalled.
// Stages: products, signed sums, clamp, four square-root stages of four
// result bits each, partial products of the motor model, final add and limit.
// All stages advance together; a stalled result holds the whole pipeline.
// Synchronous reset empties the pipeline and restores the register defaults.
module quad_motor_mixer_unit #(
   parameter int COMMAND_BITS = qmm_pkg::COMMAND_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [31:0]                 req_thrust,
   input  logic signed [31:0]                 req_roll_torque,
   input  logic signed [31:0]                 req_pitch_torque,
   input  logic signed [31:0]                 req_yaw_torque,
   input  logic                               req_armed,
   input  logic                               req_height_ref_positive,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [COMMAND_BITS-1:0]            rsp_motor1_cmd,
   output logic [COMMAND_BITS-1:0]            rsp_motor2_cmd,
   output logic [COMMAND_BITS-1:0]            rsp_motor3_cmd,
   output logic [COMMAND_BITS-1:0]            rsp_motor4_cmd,
   output logic [1:0]                         rsp_drive_mode,
   output logic                               rsp_saturated,
   input  logic                               csr_we,
   input  logic [qmm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [qmm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import qmm_pkg::*;

   localparam int NST = 9;
   localparam int SQS = 4;
   localparam int LAST = NST - 1;

   logic [31:0] thrust_gain_ff, roll_pitch_gain_ff, yaw_gain_ff;
   logic [39:0] quad_gain_ff, lin_gain_ff;
   logic [15:0] idle_level_ff;

   logic         adv;
   logic         vld_ff [NST];
   item_ctl_type ctl_ff [NST];

   logic signed [64:0] prod_ff [4];
   logic signed [66:0] sum_ff [MOTORS];
   logic signed [66:0] sum_in [MOTORS];

   // Square-root levels: level 0 is the clamped value, level SQS the finished root.
   logic [31:0] sq_v_ff   [SQS+1][MOTORS];
   logic [15:0] sq_r_ff   [SQS+1][MOTORS];
   logic [17:0] sq_rem_ff [SQS+1][MOTORS];
   logic [15:0] sq_r_in   [SQS][MOTORS];
   logic [17:0] sq_rem_in [SQS][MOTORS];
   logic        sat_ff    [SQS+2];
   logic [31:0] clamp_in  [MOTORS];
   logic        clamp_sat_in;

   logic [63:0] qlo_ff [MOTORS];
   logic [39:0] qhi_ff [MOTORS];
   logic [55:0] lin_ff [MOTORS];

   logic [COMMAND_BITS-1:0] cmd_in [MOTORS];
   logic [COMMAND_BITS-1:0] cmd_ff [MOTORS];
   logic [COMMAND_BITS-1:0] idle_cmd;
   logic                    mix_sat_in;
   logic [1:0]              mode_ff;
   logic                    rsp_sat_ff;

   // The pipeline moves whenever the output stage is empty or being taken.
   assign adv       = !vld_ff[LAST] || rsp_ready;
   assign req_ready = adv;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thrust_gain_ff     <= THRUST_GAIN_RST;
         roll_pitch_gain_ff <= ROLL_PITCH_GAIN_RST;
         yaw_gain_ff        <= YAW_GAIN_RST;
         quad_gain_ff       <= QUAD_GAIN_RST;
         lin_gain_ff        <= LIN_GAIN_RST;
         idle_level_ff      <= IDLE_LEVEL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRUST_GAIN:     thrust_gain_ff     <= csr_wdata[31:0];
            CSR_ROLL_PITCH_GAIN: roll_pitch_gain_ff <= csr_wdata[31:0];
            CSR_YAW_GAIN:        yaw_gain_ff        <= csr_wdata[31:0];
            CSR_QUAD_GAIN:       quad_gain_ff       <= csr_wdata;
            CSR_LIN_GAIN:        lin_gain_ff        <= csr_wdata;
            CSR_IDLE_LEVEL:      idle_level_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Valid bits and item control move through the stages together.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < NST; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff[0] <= '{armed: req_armed, hpos: req_height_ref_positive};
         for (int i = 1; i < NST; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   // Stage 1: the four gain products, unsigned gain times signed demand.
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff[0] <= $signed({1'b0, thrust_gain_ff}) * req_thrust;
         prod_ff[1] <= $signed({1'b0, roll_pitch_gain_ff}) * req_roll_torque;
         prod_ff[2] <= $signed({1'b0, roll_pitch_gain_ff}) * req_pitch_torque;
         prod_ff[3] <= $signed({1'b0, yaw_gain_ff}) * req_yaw_torque;
      end
   end

   // Stage 2: signed sum per motor with its sign pattern.
   always_comb begin
      logic signed [66:0] t, r, p, y;
      t = 67'(prod_ff[0]);
      r = 67'(prod_ff[1]);
      p = 67'(prod_ff[2]);
      y = 67'(prod_ff[3]);
      for (int m = 0; m < MOTORS; m++) begin
         sum_in[m] = t + (MIX_NEG[m][2] ? -r : r) + (MIX_NEG[m][1] ? -p : p)
                       + (MIX_NEG[m][0] ? -y : y);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) sum_ff <= sum_in;
   end

   // Stage 3: floor by 2^16, clamp below at zero and above at the 32-bit maximum.
   always_comb begin
      clamp_sat_in = 1'b0;
      for (int m = 0; m < MOTORS; m++) begin
         if (sum_ff[m][66]) begin
            clamp_in[m] = '0;
         end else if (sum_ff[m][65:48] != '0) begin
            clamp_in[m]  = '1;
            clamp_sat_in = 1'b1;
         end else begin
            clamp_in[m] = sum_ff[m][47:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int m = 0; m < MOTORS; m++) begin
            sq_v_ff[0][m]   <= clamp_in[m];
            sq_r_ff[0][m]   <= '0;
            sq_rem_ff[0][m] <= '0;
         end
         sat_ff[0] <= clamp_sat_in;
      end
   end

   // Stages 4 to 7: restoring square root, four result bits per stage.
   for (genvar g = 0; g < SQS; g++) begin : g_sqrt
      always_comb begin
         logic [17:0] rem;
         logic [17:0] trial;
         logic [15:0] rt;
         for (int m = 0; m < MOTORS; m++) begin
            rem = sq_rem_ff[g][m];
            rt  = sq_r_ff[g][m];
            for (int j = 0; j < 4; j++) begin
               rem   = {rem[15:0], sq_v_ff[g][m][2*(15-(4*g+j))+1 -: 2]};
               trial = {rt, 2'b01};
               if (rem >= trial) begin
                  rem = rem - trial;
                  rt  = {rt[14:0], 1'b1};
               end else begin
                  rt = {rt[14:0], 1'b0};
               end
            end
            sq_rem_in[g][m] = rem;
            sq_r_in[g][m]   = rt;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int m = 0; m < MOTORS; m++) begin
               sq_v_ff[g+1][m]   <= sq_v_ff[g][m];
               sq_r_ff[g+1][m]   <= sq_r_in[g][m];
               sq_rem_ff[g+1][m] <= sq_rem_in[g][m];
            end
            sat_ff[g+1] <= sat_ff[g];
         end
      end
   end

   // Stage 8: partial products of the motor model, quadratic gain split at bit 32.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int m = 0; m < MOTORS; m++) begin
            qlo_ff[m] <= sq_v_ff[SQS][m] * quad_gain_ff[31:0];
            qhi_ff[m] <= sq_v_ff[SQS][m] * quad_gain_ff[39:32];
            lin_ff[m] <= sq_r_ff[SQS][m] * lin_gain_ff;
         end
         sat_ff[SQS+1] <= sat_ff[SQS];
      end
   end

   // Stage 9: add, drop 32 fraction bits and limit at full scale.
   always_comb begin
      logic [72:0] tot;
      logic [40:0] cmd;
      mix_sat_in = sat_ff[SQS+1];
      for (int m = 0; m < MOTORS; m++) begin
         tot = {9'b0, qlo_ff[m]} + {1'b0, qhi_ff[m], 32'b0} + {17'b0, lin_ff[m]};
         cmd = tot[72:32];
         if (cmd[40:COMMAND_BITS] != '0 || &cmd[COMMAND_BITS-1:0]) begin
            cmd_in[m]  = '1;
            mix_sat_in = 1'b1;
         end else begin
            cmd_in[m] = cmd[COMMAND_BITS-1:0];
         end
      end
   end

   // Idle level limited to full scale.
   always_comb begin
      if (idle_level_ff > 16'({COMMAND_BITS{1'b1}})) idle_cmd = '1;
      else idle_cmd = idle_level_ff[COMMAND_BITS-1:0];
   end

   // Output register: stopped, idle or mixed result.
   always_ff @(posedge clock) begin
      if (adv) begin
         priority if (!ctl_ff[LAST-1].armed) begin
            for (int m = 0; m < MOTORS; m++) cmd_ff[m] <= '0;
            mode_ff    <= MODE_STOP;
            rsp_sat_ff <= 1'b0;
         end else if (!ctl_ff[LAST-1].hpos) begin
            for (int m = 0; m < MOTORS; m++) cmd_ff[m] <= idle_cmd;
            mode_ff    <= MODE_IDLE;
            rsp_sat_ff <= 1'b0;
         end else begin
            cmd_ff     <= cmd_in;
            mode_ff    <= MODE_MIX;
            rsp_sat_ff <= mix_sat_in;
         end
      end
   end

   assign rsp_valid      = vld_ff[LAST];
   assign rsp_motor1_cmd = cmd_ff[0];
   assign rsp_motor2_cmd = cmd_ff[1];
   assign rsp_motor3_cmd = cmd_ff[2];
   assign rsp_motor4_cmd = cmd_ff[3];
   assign rsp_drive_mode = mode_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

>>> hw/rtl/qmm_port_checker.sv
// Port-level checks for the quad motor mixer, bound to its top level.
// Depends on qmm_pkg and quad_motor_mixer_unit.
module qmm_port_checker #(
   parameter int COMMAND_BITS = qmm_pkg::COMMAND_BITS_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [COMMAND_BITS-1:0] rsp_motor1_cmd,
   input logic [COMMAND_BITS-1:0] rsp_motor2_cmd,
   input logic [COMMAND_BITS-1:0] rsp_motor3_cmd,
   input logic [COMMAND_BITS-1:0] rsp_motor4_cmd,
   input logic [1:0]              rsp_drive_mode,
   input logic                    rsp_saturated
);
   import qmm_pkg::*;

   // A waiting result stays valid, with motor 1 and 4 commands, mode and flag unchanged, until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_motor1_cmd)
         && $stable(rsp_motor4_cmd) && $stable(rsp_drive_mode) && $stable(rsp_saturated))
      else $error("result changed while stalled");

   // An empty output stage never holds back the input.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // Stopped results are all zero and never flagged.
   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_mode == MODE_STOP |-> rsp_motor1_cmd == '0
         && rsp_motor2_cmd == '0 && rsp_motor3_cmd == '0 && rsp_motor4_cmd == '0
         && !rsp_saturated)
      else $error("stopped result not zero");

   // Idle results give one level to every motor.
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_mode == MODE_IDLE |-> rsp_motor1_cmd == rsp_motor2_cmd
         && rsp_motor2_cmd == rsp_motor3_cmd && rsp_motor3_cmd == rsp_motor4_cmd
         && !rsp_saturated)
      else $error("idle result uneven");

endmodule

bind quad_motor_mixer_unit qmm_port_checker #(.COMMAND_BITS(COMMAND_BITS)) u_qmm_port_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_motor1_cmd (rsp_motor1_cmd),
   .rsp_motor2_cmd (rsp_motor2_cmd),
   .rsp_motor3_cmd (rsp_motor3_cmd),
   .rsp_motor4_cmd (rsp_motor4_cmd),
   .rsp_drive_mode (rsp_drive_mode),
   .rsp_saturated  (rsp_saturated)
);

>>> tb/quad_motor_mixer_unit_check.sv
`timescale 1ns / 100ps
// Port checker for the quad motor mixer: predicts every result from the input transfers
// and the register writes, then compares field by field. Depends on qmm_pkg.
module quad_motor_mixer_unit_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_thrust,
   input  logic signed [31:0] req_roll_torque,
   input  logic signed [31:0] req_pitch_torque,
   input  logic signed [31:0] req_yaw_torque,
   input  logic               req_armed,
   input  logic               req_height_ref_positive,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [15:0]        rsp_motor1_cmd,
   input  logic [15:0]        rsp_motor2_cmd,
   input  logic [15:0]        rsp_motor3_cmd,
   input  logic [15:0]        rsp_motor4_cmd,
   input  logic [1:0]         rsp_drive_mode,
   input  logic               rsp_saturated,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [39:0]        csr_wdata,
   output int                 fail_count,
   output int                 cmds_pending
);
   import qmm_pkg::*;

   localparam logic [15:0] FULL_SCALE = 16'hFFFF;

   typedef struct {
      logic [15:0]    cmd [MOTORS];
      drive_mode_type mode;
      logic           sat;
   } motor_cmds_type;

   // Local copy of the gain registers.
   logic [31:0] thrust_g, roll_pitch_g, yaw_g;
   logic [39:0] quad_g, lin_g;
   logic [15:0] idle_lvl;

   motor_cmds_type cmds_queue [$];

   // Floor square root of a 32-bit value, one result bit at a time.
   function automatic logic [15:0] floor_root(input logic [31:0] v);
      logic [15:0] res;
      logic [15:0] trial;
      res = '0;
      for (int b = 15; b >= 0; b--) begin
         trial = res | (16'd1 << b);
         if ({16'd0, trial} * {16'd0, trial} <= {32'd0, v})
            res = trial;
      end
      return res;
   endfunction

   // Mixes the demands into the four motor commands.
   function automatic motor_cmds_type mix_motors(input logic signed [31:0] t, r, p, y,
                                                 input logic armed, hpos);
      motor_cmds_type o;
      logic signed [71:0] tp, rp, pp, yp, acc, sq;
      logic [31:0] s;
      logic [15:0] w;
      logic [79:0] wide;
      logic [47:0] cmd;
      o.sat = 1'b0;
      if (!armed) begin
         foreach (o.cmd[k]) o.cmd[k] = '0;
         o.mode = MODE_STOP;
         return o;
      end
      if (!hpos) begin
         foreach (o.cmd[k]) o.cmd[k] = idle_lvl;
         o.mode = MODE_IDLE;
         return o;
      end
      tp = $signed({40'd0, thrust_g}) * $signed({{40{t[31]}}, t});
      rp = $signed({40'd0, roll_pitch_g}) * $signed({{40{r[31]}}, r});
      pp = $signed({40'd0, roll_pitch_g}) * $signed({{40{p[31]}}, p});
      yp = $signed({40'd0, yaw_g}) * $signed({{40{y[31]}}, y});
      for (int k = 0; k < MOTORS; k++) begin
         acc = tp;
         acc = MIX_NEG[k][2] ? acc - rp : acc + rp;
         acc = MIX_NEG[k][1] ? acc - pp : acc + pp;
         acc = MIX_NEG[k][0] ? acc - yp : acc + yp;
         sq = acc >>> 16;
         // Negative squared speed clamps to zero; overflow holds at the top and flags.
         if (sq < 0) begin
            s = '0;
         end else if (sq > 72'sh0_FFFF_FFFF) begin
            s = '1;
            o.sat = 1'b1;
         end else begin
            s = sq[31:0];
         end
         w = floor_root(s);
         wide = {40'd0, quad_g} * {48'd0, s} + {40'd0, lin_g} * {64'd0, w};
         cmd = wide[79:32];
         if (cmd >= {32'd0, FULL_SCALE}) begin
            o.cmd[k] = FULL_SCALE;
            o.sat = 1'b1;
         end else begin
            o.cmd[k] = cmd[15:0];
         end
      end
      o.mode = MODE_MIX;
      return o;
   endfunction

   assign cmds_pending = cmds_queue.size();

   // Register writes, input transfers and result checks, all sampled at the edge.
   always @(posedge clock) begin
      motor_cmds_type want;
      logic [15:0] got [MOTORS];
      if (reset) begin
         thrust_g <= THRUST_GAIN_RST;
         roll_pitch_g <= ROLL_PITCH_GAIN_RST;
         yaw_g <= YAW_GAIN_RST;
         quad_g <= QUAD_GAIN_RST;
         lin_g <= LIN_GAIN_RST;
         idle_lvl <= IDLE_LEVEL_RST;
         cmds_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_THRUST_GAIN:     thrust_g <= csr_wdata[31:0];
               CSR_ROLL_PITCH_GAIN: roll_pitch_g <= csr_wdata[31:0];
               CSR_YAW_GAIN:        yaw_g <= csr_wdata[31:0];
               CSR_QUAD_GAIN:       quad_g <= csr_wdata;
               CSR_LIN_GAIN:        lin_g <= csr_wdata;
               CSR_IDLE_LEVEL:      idle_lvl <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            cmds_queue.push_back(mix_motors(req_thrust, req_roll_torque, req_pitch_torque,
                                            req_yaw_torque, req_armed,
                                            req_height_ref_positive));
         if (rsp_valid && rsp_ready) begin
            if (cmds_queue.size() == 0) begin
               $error("result transfer with no command expected");
               fail_count++;
            end else begin
               want = cmds_queue.pop_front();
               got = '{rsp_motor1_cmd, rsp_motor2_cmd, rsp_motor3_cmd, rsp_motor4_cmd};
               for (int k = 0; k < MOTORS; k++) begin
                  if (got[k] !== want.cmd[k]) begin
                     $error("motor%0d_cmd: expected %0d, got %0d", k + 1, want.cmd[k], got[k]);
                     fail_count++;
                  end
               end
               if (rsp_drive_mode !== want.mode) begin
                  $error("drive_mode: expected %0d, got %0d", want.mode, rsp_drive_mode);
                  fail_count++;
               end
               if (rsp_saturated !== want.sat) begin
                  $error("saturated: expected %0d, got %0d", want.sat, rsp_saturated);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

>>> tb/quad_motor_mixer_unit_test.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the quad motor mixer: directed demands, then random phases
// under several register settings. Depends on qmm_pkg and the port checker.
module quad_motor_mixer_unit_test;
   import qmm_pkg::*;

   localparam logic [2:0] CSR_SPARE_A = 3'd6;
   localparam logic [2:0] CSR_SPARE_B = 3'd7;
   localparam int DRAIN_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_thrust = '0, req_roll_torque = '0;
   logic signed [31:0] req_pitch_torque = '0, req_yaw_torque = '0;
   logic req_armed = 1'b0, req_height_ref_positive = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_motor1_cmd, rsp_motor2_cmd, rsp_motor3_cmd, rsp_motor4_cmd;
   logic [1:0] rsp_drive_mode;
   logic rsp_saturated;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [39:0] csr_wdata = '0;
   int fail_count, cmds_pending;
   bit no_gaps = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   quad_motor_mixer_unit dut (.*);

   quad_motor_mixer_unit_check checker_i (.*);

   // Offers one set of demands and waits for its transfer.
   task automatic send_demand(input logic [31:0] t, r, p, y, input logic armed, hpos);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_thrust <= t;
      req_roll_torque <= r;
      req_pitch_torque <= p;
      req_yaw_torque <= y;
      req_armed <= armed;
      req_height_ref_positive <= hpos;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [39:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every command has come back and the pipeline is empty.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (cmds_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Demand values: mostly moderate, sometimes full range or an extreme.
   function automatic logic [31:0] pick_demand;
      case ($urandom_range(0, 7))
         0, 1:    return $urandom;
         2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3:       return 32'($signed($urandom_range(0, 2000)) - 1000);
         default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
   endfunction

   task automatic random_demands(input int count);
      logic armed, hpos;
      for (int i = 0; i < count; i++) begin
         armed = ($urandom_range(0, 9) != 0);
         hpos = ($urandom_range(0, 9) != 0);
         no_gaps = (i >= count / 2 && i < count / 2 + 60);
         send_demand(pick_demand(), pick_demand(), pick_demand(), pick_demand(), armed, hpos);
      end
      no_gaps = 1'b0;
   endtask

   // Result side: random stall per result, a burst with none, and one long hold-off.
   initial begin
      int stall;
      int transfers;
      transfers = 0;
      forever begin
         if (transfers == 500)
            stall = 300;
         else if (no_gaps)
            stall = 0;
         else
            stall = $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         transfers++;
      end
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: stopped, idle, extremes of each demand and sign, at reset gains.
      send_demand(32'h7FFF_FFFF, 0, 0, 0, 1'b0, 1'b1);
      send_demand(32'h7FFF_FFFF, 0, 0, 0, 1'b0, 1'b0);
      send_demand(32'd1000, 0, 0, 0, 1'b1, 1'b0);
      send_demand(0, 0, 0, 0, 1'b1, 1'b1);
      send_demand(32'd400000, 0, 0, 0, 1'b1, 1'b1);
      send_demand(32'h7FFF_FFFF, 0, 0, 0, 1'b1, 1'b1);
      send_demand(32'h8000_0000, 0, 0, 0, 1'b1, 1'b1);
      send_demand(32'd400000, 32'h7FFF_FFFF, 0, 0, 1'b1, 1'b1);
      send_demand(32'd400000, 32'h8000_0000, 0, 0, 1'b1, 1'b1);
      send_demand(32'd400000, 0, 32'h7FFF_FFFF, 0, 1'b1, 1'b1);
      send_demand(32'd400000, 0, 32'h8000_0000, 0, 1'b1, 1'b1);
      send_demand(32'd400000, 0, 0, 32'h7FFF_FFFF, 1'b1, 1'b1);
      send_demand(32'd400000, 0, 0, 32'h8000_0000, 1'b1, 1'b1);
      send_demand(32'd400000, 32'd3000000, 32'hFFD2_3940, 32'd200000, 1'b1, 1'b1);
      send_demand(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      random_demands(250);
      drain();

      // Every register at its top value, a spare index written and ignored.
      write_reg(CSR_THRUST_GAIN, 40'hFF_FFFF_FFFF);
      write_reg(CSR_ROLL_PITCH_GAIN, 40'hFF_FFFF_FFFF);
      write_reg(CSR_YAW_GAIN, 40'hFF_FFFF_FFFF);
      write_reg(CSR_QUAD_GAIN, 40'hFF_FFFF_FFFF);
      write_reg(CSR_LIN_GAIN, 40'hFF_FFFF_FFFF);
      write_reg(CSR_IDLE_LEVEL, 40'hFF_FFFF_FFFF);
      write_reg(CSR_SPARE_A, 40'h12_3456_789A);
      send_demand(32'd1, 0, 0, 0, 1'b1, 1'b1);
      send_demand(32'd5, 32'd1, 0, 0, 1'b1, 1'b0);
      random_demands(200);
      drain();

      // Every register at zero.
      for (int i = 0; i <= int'(CSR_IDLE_LEVEL); i++)
         write_reg(3'(i), '0);
      write_reg(CSR_SPARE_B, '1);
      random_demands(150);
      drain();

      // Random gains, small or full range, several times over.
      repeat (4) begin
         write_reg(CSR_THRUST_GAIN, $urandom_range(0, 1) ? 40'($urandom) :
                                    40'($urandom_range(0, 1 << 21)));
         write_reg(CSR_ROLL_PITCH_GAIN, $urandom_range(0, 1) ? 40'($urandom) :
                                        40'($urandom_range(0, 1 << 17)));
         write_reg(CSR_YAW_GAIN, $urandom_range(0, 1) ? 40'($urandom) :
                                 40'($urandom_range(0, 1 << 18)));
         write_reg(CSR_QUAD_GAIN, $urandom_range(0, 1) ? {8'($urandom), 32'($urandom)} :
                                  40'($urandom_range(0, 1 << 26)));
         write_reg(CSR_LIN_GAIN, $urandom_range(0, 1) ? {8'($urandom), 32'($urandom)} :
                                 40'($urandom) << 4);
         write_reg(CSR_IDLE_LEVEL, 40'($urandom_range(0, 65535)));
         random_demands(150);
         drain();
      end

      // Back to the usual gains.
      write_reg(CSR_THRUST_GAIN, 40'(THRUST_GAIN_RST));
      write_reg(CSR_ROLL_PITCH_GAIN, 40'(ROLL_PITCH_GAIN_RST));
      write_reg(CSR_YAW_GAIN, 40'(YAW_GAIN_RST));
      write_reg(CSR_QUAD_GAIN, QUAD_GAIN_RST);
      write_reg(CSR_LIN_GAIN, LIN_GAIN_RST);
      write_reg(CSR_IDLE_LEVEL, 40'(IDLE_LEVEL_RST));
      random_demands(100);
      drain();

      if (fail_count == 0 && cmds_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
